// ----- rtl/core/bqs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqs_pkg: shared types and constants
// Widths, register map and structs for the band-pass / sample-hold block.
// ----------------------------------------------------------------------------
package bqs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int FRAC_BITS   = COEF_BITS - 3;
  localparam int HOLD_BITS   = 6;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 5;
  localparam int NUM_REGS    = 8;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_HP_GAIN = 3'd0,
    REG_HP_FB1  = 3'd1,
    REG_HP_FB2  = 3'd2,
    REG_LP_GAIN = 3'd3,
    REG_LP_FB1  = 3'd4,
    REG_LP_FB2  = 3'd5,
    REG_BYPASS  = 3'd6,
    REG_RELOAD  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] hp_gain;
    logic [COEF_BITS-1:0] hp_fb1;
    logic [COEF_BITS-1:0] hp_fb2;
    logic [COEF_BITS-1:0] lp_gain;
    logic [COEF_BITS-1:0] lp_fb1;
    logic [COEF_BITS-1:0] lp_fb2;
    logic                 bypass;
    logic [HOLD_BITS-1:0] hold_reload;
  } cfg_t;

  // operands of one biquad section
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] x1;
    logic [SAMPLE_BITS-1:0] x2;
    logic [SAMPLE_BITS-1:0] y1;
    logic [SAMPLE_BITS-1:0] y2;
    logic [COEF_BITS-1:0]   gain;
    logic [COEF_BITS-1:0]   fb1;
    logic [COEF_BITS-1:0]   fb2;
    logic                   b1_neg;
  } mac_op_t;

endpackage
`default_nettype wire

// ----- rtl/core/bqs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqs_if: sample stream channels
// Valid/ready channels for input samples and result samples.
// ----------------------------------------------------------------------------
interface bqs_in_if;
  logic                            valid;
  logic                            ready;
  logic [bqs_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqs_out_if;
  logic                            valid;
  logic                            ready;
  logic [bqs_pkg::SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bqs_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqs_regs: configuration registers
// APB-style register file holding coefficients, bypass and hold reload.
// ----------------------------------------------------------------------------
module bqs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bqs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bqs_pkg::DATA_BITS-1:0] pwdata,
  output logic [bqs_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output bqs_pkg::cfg_t                 cfg
);
  import bqs_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{hold_reload: HOLD_BITS'(1), default: '0};
    end else if (wr) begin
      case (idx)
        REG_HP_GAIN: cfg.hp_gain     <= pwdata[COEF_BITS-1:0];
        REG_HP_FB1:  cfg.hp_fb1      <= pwdata[COEF_BITS-1:0];
        REG_HP_FB2:  cfg.hp_fb2      <= pwdata[COEF_BITS-1:0];
        REG_LP_GAIN: cfg.lp_gain     <= pwdata[COEF_BITS-1:0];
        REG_LP_FB1:  cfg.lp_fb1      <= pwdata[COEF_BITS-1:0];
        REG_LP_FB2:  cfg.lp_fb2      <= pwdata[COEF_BITS-1:0];
        REG_BYPASS:  cfg.bypass      <= pwdata[0];
        REG_RELOAD:  cfg.hold_reload <= pwdata[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HP_GAIN: prdata = DATA_BITS'(cfg.hp_gain);
      REG_HP_FB1:  prdata = DATA_BITS'(cfg.hp_fb1);
      REG_HP_FB2:  prdata = DATA_BITS'(cfg.hp_fb2);
      REG_LP_GAIN: prdata = DATA_BITS'(cfg.lp_gain);
      REG_LP_FB1:  prdata = DATA_BITS'(cfg.lp_fb1);
      REG_LP_FB2:  prdata = DATA_BITS'(cfg.lp_fb2);
      REG_BYPASS:  prdata = DATA_BITS'(cfg.bypass);
      REG_RELOAD:  prdata = DATA_BITS'(cfg.hold_reload);
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/bqs_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqs_mac: bit-serial biquad section
// Walks the coefficients one bit per cycle, LSB first, adding the selected
// data terms into a narrow right-shifting accumulator. Rounds and saturates.
// ----------------------------------------------------------------------------
module bqs_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  bqs_pkg::mac_op_t                op,
  output logic                            done,
  output logic [bqs_pkg::SAMPLE_BITS-1:0] result
);
  import bqs_pkg::*;

  localparam int PW    = SAMPLE_BITS + 3;       // per-bit partial sum
  localparam int AW    = SAMPLE_BITS + 4;       // accumulator
  localparam int LW    = COEF_BITS - FRAC_BITS + 1;
  localparam int RW    = AW + LW;
  localparam int CNT_W = $clog2(COEF_BITS);

  localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [PW-1:0]    u;
  logic signed [PW-1:0]    y1;
  logic signed [PW-1:0]    y2;
  logic [COEF_BITS-1:0]    g_sr;
  logic [COEF_BITS-1:0]    a1_sr;
  logic [COEF_BITS-1:0]    a2_sr;
  logic signed [AW-1:0]    acc;
  logic [LW-1:0]           low_sr;

  logic                    last;
  logic signed [PW-1:0]    xe, x1e2, x2e, tg, t1, t2, p_raw, p;
  logic signed [AW-1:0]    sum;
  logic signed [RW-1:0]    rnd;

  assign last = (cnt == CNT_W'(COEF_BITS - 1));

  always_comb begin
    xe    = PW'($signed(op.x));
    x1e2  = PW'($signed({op.x1, 1'b0}));
    x2e   = PW'($signed(op.x2));
    tg    = g_sr[0]  ? u  : '0;
    t1    = a1_sr[0] ? y1 : '0;
    t2    = a2_sr[0] ? y2 : '0;
    p_raw = tg - t1 - t2;
    // top coefficient bit carries negative weight
    p     = last ? -p_raw : p_raw;
    sum   = acc + AW'(p);
    rnd   = RW'($signed({acc, low_sr[LW-1:1]})) + RW'({1'b0, low_sr[0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u      <= op.b1_neg ? (xe - x1e2 + x2e) : (xe + x1e2 + x2e);
      y1     <= PW'($signed(op.y1));
      y2     <= PW'($signed(op.y2));
      g_sr   <= op.gain;
      a1_sr  <= op.fb1;
      a2_sr  <= op.fb2;
      acc    <= '0;
      low_sr <= '0;
    end else if (busy) begin
      acc    <= {sum[AW-1], sum[AW-1:1]};
      low_sr <= {sum[0], low_sr[LW-1:1]};
      g_sr   <= g_sr  >> 1;
      a1_sr  <= a1_sr >> 1;
      a2_sr  <= a2_sr >> 1;
    end
  end

  always_comb begin
    if (rnd > SAT_HI)      result = SAT_HI[SAMPLE_BITS-1:0];
    else if (rnd < SAT_LO) result = SAT_LO[SAMPLE_BITS-1:0];
    else                   result = rnd[SAMPLE_BITS-1:0];
  end

  a_start_busy : assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("section did not start");
  a_last_done : assert property (@(posedge clk) disable iff (rst)
    (busy && last && !start) |=> (done && !busy))
    else $error("section did not finish after last bit");
  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

endmodule
`default_nettype wire

// ----- rtl/core/biquad_bandpass_sample_hold.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_bandpass_sample_hold: band-pass filter with sample-and-hold
// High-pass then low-pass direct-form-I biquad, followed by a hold decimator.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. One bit-serial section unit runs the
// high-pass and then the low-pass section: a start state (ST_HP_GO, ST_LP_GO)
// launches the section, which walks its 32 coefficient bits at one bit per
// cycle, and its run state writes the section state back when it is done;
// ST_FIN then loads the result register and ST_IDLE takes the next transfer.
// In bypass a sample goes from ST_IDLE straight to ST_FIN and no filter or
// hold state moves. A result that is not taken stalls the input only once a
// second result is waiting to be loaded. The result register frees the input
// as soon as a result is loaded, so the next sample may be transferred while
// it waits.
// Coefficients are Q3.29 through the APB port, samples Q1.23; each section is
// rounded half up and saturated to 24 bits.
// ----------------------------------------------------------------------------
module biquad_bandpass_sample_hold (
  input  logic                          clk,
  input  logic                          rst,
  bqs_in_if.sink                        sample_ch,
  bqs_out_if.source                     result_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bqs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bqs_pkg::DATA_BITS-1:0] pwdata,
  output logic [bqs_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import bqs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HP_GO,
    ST_HP_RUN,
    ST_LP_GO,
    ST_LP_RUN,
    ST_FIN
  } state_t;

  state_t                 state;
  cfg_t                   cfg;
  mac_op_t                mac_op;
  logic                   mac_start;
  logic                   mac_done;
  logic [SAMPLE_BITS-1:0] mac_result;

  logic [SAMPLE_BITS-1:0] x_reg;
  logic [SAMPLE_BITS-1:0] res;
  logic [SAMPLE_BITS-1:0] hp_x1, hp_x2, hp_y1, hp_y2;
  logic [SAMPLE_BITS-1:0] lp_x1, lp_x2, lp_y1, lp_y2;
  logic [HOLD_BITS-1:0]   hold_count;
  logic [SAMPLE_BITS-1:0] held_value;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_data;
  logic                   out_load;

  bqs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bqs_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .op     (mac_op),
    .done   (mac_done),
    .result (mac_result)
  );

  assign sample_ch.ready      = (state == ST_IDLE);
  assign result_ch.valid      = out_valid;
  assign result_ch.sample_out = out_data;
  assign mac_start            = (state == ST_HP_GO) || (state == ST_LP_GO);
  assign out_load             = (state == ST_FIN) && (!out_valid || result_ch.ready);

  always_comb begin
    if (state == ST_LP_GO) begin
      // hp_y1 already holds this sample's high-pass output
      mac_op = '{x: hp_y1, x1: lp_x1, x2: lp_x2, y1: lp_y1, y2: lp_y2,
                 gain: cfg.lp_gain, fb1: cfg.lp_fb1, fb2: cfg.lp_fb2, b1_neg: 1'b0};
    end else begin
      mac_op = '{x: x_reg, x1: hp_x1, x2: hp_x2, y1: hp_y1, y2: hp_y2,
                 gain: cfg.hp_gain, fb1: cfg.hp_fb1, fb2: cfg.hp_fb2, b1_neg: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      hp_x1      <= '0;
      hp_x2      <= '0;
      hp_y1      <= '0;
      hp_y2      <= '0;
      lp_x1      <= '0;
      lp_x2      <= '0;
      lp_y1      <= '0;
      lp_y2      <= '0;
      hold_count <= '0;
      held_value <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (result_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample_ch.valid) begin
            x_reg <= sample_ch.sample_in;
            res   <= sample_ch.sample_in;
            state <= cfg.bypass ? ST_FIN : ST_HP_GO;
          end
        end
        ST_HP_GO: state <= ST_HP_RUN;
        ST_HP_RUN: begin
          if (mac_done) begin
            hp_x2 <= hp_x1;
            hp_x1 <= x_reg;
            hp_y2 <= hp_y1;
            hp_y1 <= mac_result;
            state <= ST_LP_GO;
          end
        end
        ST_LP_GO: state <= ST_LP_RUN;
        ST_LP_RUN: begin
          if (mac_done) begin
            lp_x2 <= lp_x1;
            lp_x1 <= hp_y1;
            lp_y2 <= lp_y1;
            lp_y1 <= mac_result;
            if (hold_count == '0) begin
              held_value <= mac_result;
              hold_count <= cfg.hold_reload;
              res        <= mac_result;
            end else begin
              hold_count <= hold_count - HOLD_BITS'(1);
              res        <= held_value;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_in_run : assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_HP_RUN || state == ST_LP_RUN))
    else $error("section result outside a run state");
  a_bypass_fin : assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready && cfg.bypass) |=> (state == ST_FIN))
    else $error("bypass sample entered the filter");
  a_hold_latch : assert property (@(posedge clk) disable iff (rst)
    (state == ST_LP_RUN && mac_done && hold_count == '0)
      |=> (held_value == $past(mac_result)))
    else $error("hold stage missed a latch");
  a_fin_loads : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && (!out_valid || result_ch.ready))
      |=> (out_valid && out_data == $past(res)))
    else $error("result register not loaded");

endmodule
`default_nettype wire
